FILE: rtl/core/dnkf_pkg.sv
// Shared types, constants and helpers of the DNS name keyword filter.
package dnkf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HIST_W   = 48;
    localparam int unsigned LABEL_W  = 6;

    // Keywords, first character in the highest byte.
    localparam logic [39:0] KW_PHISH   = 40'h7068697368;
    localparam logic [39:0] KW_TRACK   = 40'h747261636B;
    localparam logic [47:0] KW_ADSERV  = 48'h616473657276;
    localparam logic [55:0] KW_MALWARE = 56'h6D616C77617265;

    localparam logic [BYTE_W-1:0] SEP_CHAR  = 8'h2E;
    localparam logic [BYTE_W-1:0] DASH_CHAR = 8'h2D;

    // Parser state carried from one name byte to the next.
    typedef struct packed {
        logic [HIST_W-1:0]  recent_bytes;
        logic [LABEL_W-1:0] label_left;
        logic               in_name;
        logic               saw_bad;
        logic               saw_keyword;
    } t_name_state;

    typedef struct packed {
        logic verdict;
        logic bad_character;
        logic keyword_hit;
    } t_verdict;

    // Letters, digits and '-' are legal inside a label.
    function automatic logic allowed_char(input logic [BYTE_W-1:0] c);
        logic ok;
        ok = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) ||
             (c == DASH_CHAR);
        return ok;
    endfunction

endpackage

FILE: rtl/core/dnkf_if.sv
// Valid/ready channel interfaces for name bytes and verdicts.
interface dnkf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;
    logic       payload_end;

    modport source (output valid, output data_byte, output start_req,
                    output payload_end, input ready);
    modport sink   (input valid, input data_byte, input start_req,
                    input payload_end, output ready);
endinterface

interface dnkf_out_if;
    logic valid;
    logic ready;
    logic verdict;
    logic bad_character;
    logic keyword_hit;

    modport source (output valid, output verdict, output bad_character,
                    output keyword_hit, input ready);
    modport sink   (input valid, input verdict, input bad_character,
                    input keyword_hit, output ready);
endinterface

FILE: rtl/core/dns_name_keyword_filter.sv
// Top level of the DNS question-name keyword filter.
// Takes the bytes of a DNS question name in wire format, one per transfer on
// i_in, and gives one verdict transfer on o_out per name: block (1) when a
// label held a byte other than a letter, digit or '-', when a length byte was
// above 63, or when "phish", "malware", "track" or "adserv" appeared in the
// dotted name (length bytes count as '.'). A name begins at a byte with
// start_req set and ends at a zero length byte or at payload_end; bytes
// outside a name give nothing. Rate: one byte per clock when o_out is not
// stalled; the byte that ended the name passes the input register, then the
// single-pass parser into the result register, which gives the verdict. No
// clearing pass after reset.
module dns_name_keyword_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dnkf_in_if.sink           i_in,
    dnkf_out_if.source        o_out
);
    import dnkf_pkg::*;

    // Input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_start;
    logic              r_s1_end;

    // Parser state
    t_name_state r_state;
    t_name_state n_state;

    // Result register
    logic     r_out_valid;
    t_verdict r_out;

    logic     step_emit;
    t_verdict step_result;
    logic     out_free;
    logic     s1_advance;

    // Result register can take a new verdict when empty or being drained.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_advance = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    dnkf_step u_step (
        .i_state       (r_state),
        .i_data_byte   (r_s1_byte),
        .i_start_req   (r_s1_start),
        .i_payload_end (r_s1_end),
        .o_state       (n_state),
        .o_emit        (step_emit),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= s1_advance && step_emit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte  <= i_in.data_byte;
            r_s1_start <= i_in.start_req;
            r_s1_end   <= i_in.payload_end;
        end
        if (s1_advance && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.verdict       = r_out.verdict;
    assign o_out.bad_character = r_out.bad_character;
    assign o_out.keyword_hit   = r_out.keyword_hit;

endmodule

FILE: rtl/core/dnkf_step.sv
// One-byte step of the wire-format name parser and keyword matcher.
module dnkf_step (
    input  dnkf_pkg::t_name_state i_state,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_start_req,
    input  logic                  i_payload_end,
    output dnkf_pkg::t_name_state o_state,
    output logic                  o_emit,
    output dnkf_pkg::t_verdict    o_result
);
    import dnkf_pkg::*;

    t_name_state     base;
    logic [BYTE_W-1:0] push_char;
    logic            do_push;
    logic [55:0]     window;
    logic            kw_match;
    logic            done;
    logic            bad_now;

    always_comb begin
        base = i_state;
        if (i_start_req) begin
            base.recent_bytes = '0;
            base.label_left   = '0;
            base.saw_bad      = 1'b0;
            base.saw_keyword  = 1'b0;
            base.in_name      = 1'b1;
        end
    end

    // Length byte or label byte
    always_comb begin
        done      = 1'b0;
        bad_now   = 1'b0;
        do_push   = 1'b0;
        push_char = i_data_byte;
        o_state   = base;
        if (base.label_left == '0) begin
            if (i_data_byte == '0) begin
                done = 1'b1;
            end else if (i_data_byte[7:6] != 2'b00) begin
                // compression pointer or reserved form
                bad_now = 1'b1;
                done    = 1'b1;
            end else begin
                o_state.label_left = i_data_byte[LABEL_W-1:0];
                push_char          = SEP_CHAR;
                do_push            = 1'b1;
            end
        end else begin
            o_state.label_left = base.label_left - LABEL_W'(1);
            bad_now            = !allowed_char(i_data_byte);
            do_push            = 1'b1;
        end

        window   = {base.recent_bytes, push_char};
        kw_match = (window[39:0] == KW_PHISH) || (window[39:0] == KW_TRACK) ||
                   (window[47:0] == KW_ADSERV) || (window == KW_MALWARE);

        if (do_push) begin
            o_state.recent_bytes = window[HIST_W-1:0];
        end
        o_state.saw_bad     = base.saw_bad | bad_now;
        o_state.saw_keyword = base.saw_keyword | (do_push & kw_match);

        if (i_payload_end) begin
            done = 1'b1;
        end
        o_emit = base.in_name & done;
        if (!base.in_name) begin
            o_state = base;
        end else if (done) begin
            o_state.in_name    = 1'b0;
            o_state.label_left = '0;
        end

        o_result.bad_character = o_state.saw_bad;
        o_result.keyword_hit   = o_state.saw_keyword;
        o_result.verdict       = o_state.saw_bad | o_state.saw_keyword;
    end

endmodule

FILE: bench/dns_name_keyword_filter_test.sv
// Self-checking testbench of the DNS question-name keyword filter.
`timescale 1ns / 100ps

module dns_name_keyword_filter_test;

    // Keyword patterns, first character in the highest byte.
    localparam logic [39:0] PAT_PHISH   = "phish";
    localparam logic [39:0] PAT_TRACK   = "track";
    localparam logic [47:0] PAT_ADSERV  = "adserv";
    localparam logic [55:0] PAT_MALWARE = "malware";

    localparam logic [7:0] DOT_BYTE    = 8'h2E;
    localparam logic [7:0] HYPHEN_BYTE = 8'h2D;
    localparam logic [7:0] ROOT_LEN    = 8'h00;
    localparam int         MAX_LEN     = 63;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int QUIET_LIMIT  = 3000;
    // Cycles to wait after the last expected verdict, to catch stray results.
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_BYTES  = 340;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dnkf_in_if  in_bus ();
    dnkf_out_if out_bus ();

    dns_name_keyword_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idling controls, percent of cycles.
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    int errors       = 0;
    int parsed_bytes = 0;
    int quiet_cycles = 0;

    string keyword_text [4] = '{"phish", "malware", "track", "adserv"};

    // ------------------------------------------------------------------
    // Name parser mirror: history of dotted name bytes, label countdown,
    // and per-name flags. Verdicts it predicts wait in pending_verdicts.
    // ------------------------------------------------------------------
    logic [47:0] name_hist;
    logic [5:0]  label_remaining;
    logic        parsing;
    logic        flag_bad;
    logic        flag_keyword;

    dnkf_pkg::t_verdict pending_verdicts [$];

    function automatic logic is_label_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || (c == HYPHEN_BYTE);
    endfunction

    // Shift one byte into the history; the 7-byte window including the new
    // byte is what the keyword compare looks at.
    function automatic void shift_name_byte(input logic [7:0] c);
        logic [55:0] window;
        window = {name_hist, c};
        if (window[39:0] == PAT_PHISH || window[39:0] == PAT_TRACK ||
            window[47:0] == PAT_ADSERV || window == PAT_MALWARE)
            flag_keyword = 1'b1;
        name_hist = window[47:0];
    endfunction

    function automatic void predict_name_byte(input logic [7:0] b, input logic st,
                                              input logic pe);
        logic               done;
        dnkf_pkg::t_verdict v;
        done = 1'b0;
        // A start request wipes any name in progress without a verdict.
        if (st) begin
            name_hist       = '0;
            label_remaining = '0;
            flag_bad        = 1'b0;
            flag_keyword    = 1'b0;
            parsing         = 1'b1;
        end
        if (!parsing)
            return;
        parsed_bytes++;
        if (label_remaining == 0) begin
            // Length byte: zero ends the name, above 63 is a pointer or
            // reserved form and ends it as bad, else it reads as a dot.
            if (b == ROOT_LEN) begin
                done = 1'b1;
            end else if (b > MAX_LEN) begin
                flag_bad = 1'b1;
                done     = 1'b1;
            end else begin
                label_remaining = b[5:0];
                shift_name_byte(DOT_BYTE);
            end
        end else begin
            label_remaining = label_remaining - 6'd1;
            if (!is_label_char(b))
                flag_bad = 1'b1;
            shift_name_byte(b);
        end
        if (pe)
            done = 1'b1;
        if (done) begin
            v.verdict       = flag_bad | flag_keyword;
            v.bad_character = flag_bad;
            v.keyword_hit   = flag_keyword;
            pending_verdicts.push_back(v);
            parsing         = 1'b0;
            label_remaining = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: random idle gaps, then hold the byte until its transfer.
    // Called and returns at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic st, input logic pe);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.data_byte   <= b;
        in_bus.start_req   <= st;
        in_bus.payload_end <= pe;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        predict_name_byte(b, st, pe);
        @(negedge i_clk);
    endtask

    // Receiver backpressure.
    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Verdict checker: every verdict transfer against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input logic want,
                                        input logic got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %b actual %b", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_verdicts
        dnkf_pkg::t_verdict want;
        if (i_rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: verdict with none expected, expected none actual %b/%b/%b",
                         $time, out_bus.verdict, out_bus.bad_character,
                         out_bus.keyword_hit);
            end else begin
                want = pending_verdicts.pop_front();
                check_field("verdict", want.verdict, out_bus.verdict);
                check_field("bad_character", want.bad_character, out_bus.bad_character);
                check_field("keyword_hit", want.keyword_hit, out_bus.keyword_hit);
            end
        end
    end

    // Watchdog on progress of both channels.
    always @(posedge i_clk) begin
        if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
            (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Bytes while no name is open are dropped, payload end included.
    task automatic test_outside_bytes();
        send_byte(8'hFF, 1'b0, 1'b1);
    endtask

    // "\5phish\0": keyword hit, clean characters.
    task automatic test_keyword_name();
        send_byte(8'h05, 1'b1, 1'b0);
        send_byte("p", 1'b0, 1'b0);
        send_byte("h", 1'b0, 1'b0);
        send_byte("i", 1'b0, 1'b0);
        send_byte("s", 1'b0, 1'b0);
        send_byte("h", 1'b0, 1'b0);
        send_byte(ROOT_LEN, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);   // name already closed: ignored
    endtask

    // Compression pointer and the smallest reserved length end the name as bad.
    task automatic test_bad_length();
        send_byte(8'hC0, 1'b1, 1'b0);
        send_byte(8'h40, 1'b1, 1'b0);
    endtask

    // Extreme bytes and a literal dot inside a label, cut off by payload end.
    task automatic test_truncated_label();
        send_byte(8'h03, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(DOT_BYTE, 1'b0, 1'b1);
    endtask

    // Keyword seen, then a restart: flags cleared, the restart byte is both a
    // zero length and the payload end, and gives exactly one clean verdict.
    task automatic test_restart();
        send_byte(8'h05, 1'b1, 1'b0);
        send_byte("t", 1'b0, 1'b0);
        send_byte("r", 1'b0, 1'b0);
        send_byte("a", 1'b0, 1'b0);
        send_byte("c", 1'b0, 1'b0);
        send_byte("k", 1'b0, 1'b0);
        send_byte(ROOT_LEN, 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random names
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_label_char();
        int r;
        r = $urandom_range(62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r < 62)
            return 8'("0" + r - 52);
        return HYPHEN_BYTE;
    endfunction

    // Mostly well-formed wire names with keywords, near misses and bad bytes
    // sprinkled in; some end on a pointer or reserved length byte, some are
    // cut short by payload end, some are simply abandoned for the next start.
    task automatic send_random_name();
        logic [7:0] wire_q [$];
        int         n_labels;
        int         len;
        int         base;
        int         k;
        int         klen;
        int         pos;
        int         r;
        int         end_kind;
        logic       end_pe;
        n_labels = $urandom_range(4);
        end_pe   = 1'b0;
        for (int l = 0; l < n_labels; l++) begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(10, 1);
            else if (r < 95)
                len = $urandom_range(20, 11);
            else
                len = $urandom_range(MAX_LEN, 50);
            wire_q.push_back(8'(len));
            base = wire_q.size();
            for (int i = 0; i < len; i++)
                wire_q.push_back(random_label_char());
            if ($urandom_range(99) < 45) begin
                k    = $urandom_range(3);
                klen = keyword_text[k].len();
                if (klen <= len) begin
                    pos = base + $urandom_range(len - klen);
                    for (int i = 0; i < klen; i++)
                        wire_q[pos + i] = keyword_text[k][i];
                    // near miss: one character swapped
                    if ($urandom_range(3) == 0)
                        wire_q[pos + $urandom_range(klen - 1)] = random_label_char();
                end
            end
            if ($urandom_range(99) < 8)
                wire_q[base + $urandom_range(len - 1)] = 8'($urandom_range(255));
        end
        end_kind = $urandom_range(99);
        if (end_kind < 72) begin
            wire_q.push_back(ROOT_LEN);
            end_pe = ($urandom_range(99) < 15);
        end else if (end_kind < 80) begin
            wire_q.push_back(8'($urandom_range(255, MAX_LEN + 1)));
        end else begin
            if (wire_q.size() == 0)
                wire_q.push_back(ROOT_LEN);
            pos = $urandom_range(wire_q.size() - 1);
            while (wire_q.size() > pos + 1)
                void'(wire_q.pop_back());
            end_pe = (end_kind < 92);
        end
        foreach (wire_q[i])
            send_byte(wire_q[i], i == 0, (i == wire_q.size() - 1) && end_pe);
    endtask

    task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                       input int stall);
        int target;
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        target          = parsed_bytes + n_bytes;
        while (parsed_bytes < target) begin
            // stray bytes between names, ignored unless a name was abandoned
            if ($urandom_range(99) < 6)
                repeat ($urandom_range(3, 1))
                    send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            send_random_name();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n               = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = 8'h00;
        in_bus.start_req      = 1'b0;
        in_bus.payload_end    = 1'b0;
        out_bus.ready         = 1'b0;
        name_hist             = '0;
        label_remaining       = '0;
        parsing               = 1'b0;
        flag_bad              = 1'b0;
        flag_keyword          = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_outside_bytes();
        test_keyword_name();
        test_bad_length();
        test_truncated_label();
        test_restart();

        test_random_traffic(PHASE_BYTES, 0, 0);
        test_random_traffic(PHASE_BYTES, 88, 0);
        test_random_traffic(PHASE_BYTES, 0, 88);
        test_random_traffic(PHASE_BYTES, 34, 34);

        in_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
